FILE: sv/rgi_pkg.sv
// shared types, constants and lookup functions for the rgb gamma block
`timescale 1ns / 1ps
`default_nettype none

package rgi_pkg;

    // curve geometry
    localparam int CURVE_POINTS = 17;
    localparam int PTR_W        = 5;
    localparam int SAMPLE_W     = 10;
    localparam int LEVEL_W      = 8;
    localparam int FRAC_W       = 6;
    localparam int CHAN_W       = 2;
    localparam int NUM_CHAN     = 3;

    // apb register file
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef logic [PTR_W-1:0]    ptr_t;
    typedef logic [LEVEL_W-1:0]  level_t;
    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [CHAN_W-1:0]   chan_t;
    typedef logic signed [2:0]   offset_t;

    // item kinds
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_TABLE = 1'b1;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_GAMMA_EN  = 2'd0;
    localparam logic [1:0] REG_DITHER_EN = 2'd1;
    localparam logic [1:0] REG_TEN_BIT   = 2'd2;

    // curve write request into one curve memory
    typedef struct packed {
        logic   en;
        ptr_t   addr;
        level_t data;
    } curve_wr_t;

    // power-up curve point
    function automatic level_t default_point(ptr_t idx);
        level_t pt;
        unique case (idx)
            5'd0:    pt = 8'h03;
            5'd1:    pt = 8'h13;
            5'd2:    pt = 8'h2b;
            5'd3:    pt = 8'h48;
            5'd4:    pt = 8'h62;
            5'd5:    pt = 8'h7b;
            5'd6:    pt = 8'h93;
            5'd7:    pt = 8'ha8;
            5'd8:    pt = 8'hba;
            5'd9:    pt = 8'hca;
            5'd10:   pt = 8'hd7;
            5'd11:   pt = 8'he3;
            5'd12:   pt = 8'hec;
            5'd13:   pt = 8'hf4;
            5'd14:   pt = 8'hfa;
            default: pt = 8'hff;
        endcase
        return pt;
    endfunction

    // ordered dither entry minus two; rows {1,3,1,3} even, {4,2,4,2} odd
    function automatic offset_t dither_offset(logic [1:0] line, logic [1:0] col);
        offset_t off;
        unique case ({line[0], col[0]})
            2'b00:   off = -3'sd1;
            2'b01:   off = 3'sd1;
            2'b10:   off = 3'sd2;
            default: off = 3'sd0;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

FILE: sv/rgi_pix_if.sv
// input channel: pixel and curve-write words
`timescale 1ns / 1ps
`default_nettype none

interface rgi_pix_if import rgi_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    func;
    sample_t red_in;
    sample_t green_in;
    sample_t blue_in;
    logic    line_end;
    logic    frame_start;
    chan_t   table_channel;
    ptr_t    table_index;
    level_t  table_value;

    modport source (
        output valid, func, red_in, green_in, blue_in, line_end, frame_start,
               table_channel, table_index, table_value,
        input  ready
    );

    modport sink (
        input  valid, func, red_in, green_in, blue_in, line_end, frame_start,
               table_channel, table_index, table_value,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/rgi_rgb_if.sv
// output channel: corrected 8-bit rgb words
`timescale 1ns / 1ps
`default_nettype none

interface rgi_rgb_if import rgi_pkg::*; ();
    logic   valid;
    logic   ready;
    level_t red_out;
    level_t green_out;
    level_t blue_out;

    modport source (
        output valid, red_out, green_out, blue_out,
        input  ready
    );

    modport sink (
        input  valid, red_out, green_out, blue_out,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/rgi_curve_mem.sv
// one 17-point curve memory: one write port, two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module rgi_curve_mem import rgi_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire curve_wr_t wr,
    input  wire logic      rd_en,
    input  wire ptr_t      rd_addr_a,
    input  wire ptr_t      rd_addr_b,
    output level_t         y_a,
    output level_t         y_b
);

    level_t mem [CURVE_POINTS];

    logic [CURVE_POINTS-1:0] valid_reg;
    logic [CURVE_POINTS-1:0] valid_next;

    level_t rd_a_reg;
    level_t rd_b_reg;
    level_t def_a_reg;
    level_t def_b_reg;
    logic   vld_a_reg;
    logic   vld_b_reg;

    // written points stop falling back to the power-up curve
    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // storage array and registered reads
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_a_reg  <= mem[rd_addr_a];
            rd_b_reg  <= mem[rd_addr_b];
            vld_a_reg <= valid_reg[rd_addr_a];
            vld_b_reg <= valid_reg[rd_addr_b];
            def_a_reg <= default_point(rd_addr_a);
            def_b_reg <= default_point(rd_addr_b);
        end
    end

    // unwritten points read as the power-up curve
    assign y_a = vld_a_reg ? rd_a_reg : def_a_reg;
    assign y_b = vld_b_reg ? rd_b_reg : def_b_reg;

endmodule

`default_nettype wire

FILE: sv/rgb_gamma_interpolate_dither.sv
// top level: rgb gamma correction with ordered dither and apb registers
`timescale 1ns / 1ps
`default_nettype none

// Per-pixel RGB gamma correction. Each channel has a 17-point 8-bit curve held
// in its own small memory with two read ports; a pixel's 10-bit value picks a
// segment with its upper 4 bits and interpolates between the two end points
// with its lower 6 bits. Input words with func set rewrite one curve point and
// give no output word. The block takes one word per clock while its read stage
// is free. The curve memory read (both segment end points in parallel) is
// launched at the accepting edge, and the pixel's result is loaded into the
// output register once that register is empty or being taken. A held output
// word stalls the input only once the read stage behind it is also full. A
// curve write is seen by the very next pixel. The curves come out of reset at
// the default gamma curve with no clearing pass, so words are accepted from
// the first cycle after reset.
// Registers on the APB port: 0x0 gamma_enable, 0x4 dither_enable,
// 0x8 ten_bit_input; change them only while no pixel is in flight.
module rgb_gamma_interpolate_dither import rgi_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    rgi_pix_if.sink                 pix_in,
    rgi_rgb_if.source               rgb_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    // bring a sample to 10 bits, dither and clamp when enabled
    function automatic sample_t widen_sample(sample_t raw, logic ten_bit, logic dither,
                                             offset_t off);
        logic [SAMPLE_W+1:0] sum;
        sample_t             res;
        sum = {2'b00, raw} + (dither ? {{(SAMPLE_W-1){off[2]}}, off} : '0);
        if (!ten_bit)
        begin
            res = {raw[LEVEL_W-1:0], 2'b00};
        end
        else if (sum[SAMPLE_W+1])
        begin
            res = '0;
        end
        else if (sum[SAMPLE_W])
        begin
            res = '1;
        end
        else
        begin
            res = sum[SAMPLE_W-1:0];
        end
        return res;
    endfunction

    // configuration registers
    logic gamma_en_reg,  gamma_en_next;
    logic dither_en_reg, dither_en_next;
    logic ten_bit_reg,   ten_bit_next;
    logic cfg_wr;

    // dither position
    logic [1:0] col_phase_reg, col_phase_next;
    logic [1:0] line_phase_reg, line_phase_next;
    logic [1:0] col_cur;
    logic [1:0] line_cur;
    offset_t    offset;

    // handshake and stage control
    logic in_acc;
    logic is_pixel;
    logic s1_free;
    logic out_load;
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;

    // per-channel datapath
    sample_t raw_in [NUM_CHAN];
    sample_t wide   [NUM_CHAN];
    sample_t s1_sample_reg [NUM_CHAN];
    logic    s1_gamma_reg;
    level_t  y1 [NUM_CHAN];
    level_t  y2 [NUM_CHAN];
    level_t  level_calc [NUM_CHAN];
    level_t  out_level_reg [NUM_CHAN];

    // apb register access, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb
    begin
        gamma_en_next  = gamma_en_reg;
        dither_en_next = dither_en_reg;
        ten_bit_next   = ten_bit_reg;
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_GAMMA_EN:  gamma_en_next  = pwdata[0];
                REG_DITHER_EN: dither_en_next = pwdata[0];
                REG_TEN_BIT:   ten_bit_next   = pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_GAMMA_EN:  prdata[0] = gamma_en_reg;
            REG_DITHER_EN: prdata[0] = dither_en_reg;
            REG_TEN_BIT:   prdata[0] = ten_bit_reg;
            default:       prdata    = '0;
        endcase
    end

    // input side handshake
    assign out_load     = s1_valid_reg & (~out_valid_reg | rgb_out.ready);
    assign s1_free      = ~s1_valid_reg | out_load;
    assign pix_in.ready = s1_free;
    assign in_acc       = pix_in.valid & s1_free;
    assign is_pixel     = (pix_in.func == FUNC_PIXEL);

    // frame start clears the position before the pixel uses it
    assign col_cur  = pix_in.frame_start ? 2'd0 : col_phase_reg;
    assign line_cur = pix_in.frame_start ? 2'd0 : line_phase_reg;
    assign offset   = dither_offset(line_cur, col_cur);

    always_comb
    begin
        col_phase_next  = col_phase_reg;
        line_phase_next = line_phase_reg;
        if (in_acc && is_pixel)
        begin
            if (pix_in.line_end)
            begin
                col_phase_next  = 2'd0;
                line_phase_next = line_cur + 2'd1;
            end
            else
            begin
                col_phase_next  = col_cur + 2'd1;
                line_phase_next = line_cur;
            end
        end
    end

    assign raw_in[0] = pix_in.red_in;
    assign raw_in[1] = pix_in.green_in;
    assign raw_in[2] = pix_in.blue_in;

    // stage and output valid tracking
    always_comb
    begin
        s1_valid_next = s1_free ? (in_acc & is_pixel) : s1_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rgb_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_en_reg   <= 1'b1;
            dither_en_reg  <= 1'b0;
            ten_bit_reg    <= 1'b0;
            col_phase_reg  <= 2'd0;
            line_phase_reg <= 2'd0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            gamma_en_reg   <= gamma_en_next;
            dither_en_reg  <= dither_en_next;
            ten_bit_reg    <= ten_bit_next;
            col_phase_reg  <= col_phase_next;
            line_phase_reg <= line_phase_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_gamma_reg <= gamma_en_reg;
        end
    end

    // per-channel curve memory, interpolation and output register
    for (genvar ch = 0; ch < NUM_CHAN; ch++)
    begin : g_chan
        curve_wr_t          wr;
        ptr_t               seg_lo;
        ptr_t               seg_hi;
        logic               rising;
        level_t             diff;
        logic [FRAC_W-1:0]  frac;
        logic [LEVEL_W+FRAC_W-1:0] prod;
        logic [LEVEL_W+FRAC_W-1:0] prod_up;
        level_t             interp;

        assign wide[ch] = widen_sample(raw_in[ch], ten_bit_reg,
                                       dither_en_reg & ten_bit_reg, offset);

        // curve write for this channel, out-of-range points dropped
        assign wr.en   = in_acc & (pix_in.func == FUNC_TABLE)
                         & (pix_in.table_channel == CHAN_W'(ch))
                         & (pix_in.table_index < PTR_W'(CURVE_POINTS));
        assign wr.addr = pix_in.table_index;
        assign wr.data = pix_in.table_value;

        // segment end points
        assign seg_lo = {1'b0, wide[ch][SAMPLE_W-1:FRAC_W]};
        assign seg_hi = seg_lo + PTR_W'(1);

        rgi_curve_mem u_curve (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr        (wr),
            .rd_en     (s1_free),
            .rd_addr_a (seg_lo),
            .rd_addr_b (seg_hi),
            .y_a       (y1[ch]),
            .y_b       (y2[ch])
        );

        always_ff @(posedge clk)
        begin
            if (s1_free)
            begin
                s1_sample_reg[ch] <= wide[ch];
            end
        end

        // linear interpolation; a falling segment rounds toward minus infinity
        assign frac    = s1_sample_reg[ch][FRAC_W-1:0];
        assign rising  = (y2[ch] >= y1[ch]);
        assign diff    = rising ? (y2[ch] - y1[ch]) : (y1[ch] - y2[ch]);
        assign prod    = {{FRAC_W{1'b0}}, diff} * {{LEVEL_W{1'b0}}, frac};
        assign prod_up = prod + (LEVEL_W+FRAC_W)'(2**FRAC_W - 1);
        assign interp  = rising ? (y1[ch] + prod[LEVEL_W+FRAC_W-1:FRAC_W])
                                : (y1[ch] - prod_up[LEVEL_W+FRAC_W-1:FRAC_W]);

        assign level_calc[ch] = s1_gamma_reg ? interp
                                             : s1_sample_reg[ch][SAMPLE_W-1:SAMPLE_W-LEVEL_W];

        always_ff @(posedge clk)
        begin
            if (out_load)
            begin
                out_level_reg[ch] <= level_calc[ch];
            end
        end
    end

    // output word
    assign rgb_out.valid     = out_valid_reg;
    assign rgb_out.red_out   = out_level_reg[0];
    assign rgb_out.green_out = out_level_reg[1];
    assign rgb_out.blue_out  = out_level_reg[2];

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// self-checking testbench for the rgb gamma block with its own pixel predictor
`timescale 1ns / 1ps

module testbench;
    import rgi_pkg::*;

    // one input word as the bench queues it
    typedef struct packed {
        logic    func;
        sample_t red;
        sample_t green;
        sample_t blue;
        logic    line_end;
        logic    frame_start;
        chan_t   table_channel;
        ptr_t    table_index;
        level_t  table_value;
    } pix_word_t;

    // one corrected pixel
    typedef struct packed {
        level_t red;
        level_t green;
        level_t blue;
    } rgb_word_t;

    localparam chan_t CH_RED   = 2'd0;
    localparam chan_t CH_GREEN = 2'd1;
    localparam chan_t CH_BLUE  = 2'd2;
    localparam chan_t CH_NONE  = 2'd3;

    localparam int HOLD_CYCLES      = 150;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RANDOM_PER_PHASE = 50;
    localparam int NUM_PHASES       = 8;
    localparam int DRAIN_CYCLES     = 4;

    // power-up curve, point 0 in the low byte
    localparam logic [8*CURVE_POINTS-1:0] POWER_UP_CURVE = {
        8'hff, 8'hff, 8'hfa, 8'hf4, 8'hec, 8'he3, 8'hd7, 8'hca, 8'hba,
        8'ha8, 8'h93, 8'h7b, 8'h62, 8'h48, 8'h2b, 8'h13, 8'h03
    };

    logic               clk;
    logic               rst_n   = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // bench-side copies of the channel controls, known from time zero
    logic      bus_valid  = 1'b0;
    pix_word_t bus_word   = '0;
    logic      sink_ready = 1'b0;

    // traffic shaping
    int   send_gap_pct = 0;
    int   stall_pct    = 0;
    logic squeeze_req  = 1'b0;
    logic squeeze_ack  = 1'b0;
    int   hold_left    = 0;
    int   quiet_cycles = 0;
    int   mismatch_cnt = 0;

    // predictor state
    level_t     curve_pt [NUM_CHAN][CURVE_POINTS];
    logic [1:0] col_ph;
    logic [1:0] row_ph;
    logic       gamma_on  = 1'b1;
    logic       dither_on = 1'b0;
    logic       wide_in   = 1'b0;

    pix_word_t word_backlog [$];
    rgb_word_t corrected_q [$];

    rgi_pix_if pix_bus ();
    rgi_rgb_if rgb_bus ();

    assign pix_bus.valid         = bus_valid;
    assign pix_bus.func          = bus_word.func;
    assign pix_bus.red_in        = bus_word.red;
    assign pix_bus.green_in      = bus_word.green;
    assign pix_bus.blue_in       = bus_word.blue;
    assign pix_bus.line_end      = bus_word.line_end;
    assign pix_bus.frame_start   = bus_word.frame_start;
    assign pix_bus.table_channel = bus_word.table_channel;
    assign pix_bus.table_index   = bus_word.table_index;
    assign pix_bus.table_value   = bus_word.table_value;
    assign rgb_bus.ready         = sink_ready;

    rgb_gamma_interpolate_dither dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_bus),
        .rgb_out (rgb_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ordered dither entry minus two: rows alternate {1,3,1,3} and {4,2,4,2}
    function automatic int dither_bias(logic [1:0] row, logic [1:0] col);
        if (row[0])
            return col[0] ? 0 : 2;
        return col[0] ? 1 : -1;
    endfunction

    // bring a sample to 10 bits, dithered and clamped when enabled
    function automatic int widen_sample(sample_t s, int bias);
        int x;
        if (!wide_in)
            return int'({s[7:0], 2'b00});
        x = int'(s) + (dither_on ? bias : 0);
        if (x > 1023)
            x = 1023;
        if (x < 0)
            x = 0;
        return x;
    endfunction

    // one channel through its curve, or reduced to 8 bits in bypass
    function automatic level_t shade(chan_t ch, sample_t s, int bias);
        int v;
        int seg;
        int frac;
        int y1;
        int y2;
        int r;
        if (!gamma_on)
        begin
            if (!wide_in)
                return s[7:0];
            r = widen_sample(s, bias) >> 2;
            return r[7:0];
        end
        v    = widen_sample(s, bias);
        seg  = v >> 6;
        frac = v & 63;
        y1   = int'(curve_pt[ch][seg]);
        y2   = int'(curve_pt[ch][seg + 1]);
        // falling segments round toward minus infinity
        if (y2 >= y1)
            r = y1 + (((y2 - y1) * frac) >> 6);
        else
            r = y1 - ((((y1 - y2) * frac) + 63) >> 6);
        if (r > 255)
            r = 255;
        return r[7:0];
    endfunction

    // advance the predictor by one accepted word
    task automatic absorb_word(input pix_word_t w);
        rgb_word_t e;
        int        bias;
        if (w.func == FUNC_TABLE)
        begin
            // out-of-range channel or point is dropped
            if (w.table_channel < NUM_CHAN && w.table_index < CURVE_POINTS)
                curve_pt[w.table_channel][w.table_index] = w.table_value;
        end
        else
        begin
            if (w.frame_start)
            begin
                col_ph = 2'd0;
                row_ph = 2'd0;
            end
            bias    = dither_bias(row_ph, col_ph);
            e.red   = shade(CH_RED, w.red, bias);
            e.green = shade(CH_GREEN, w.green, bias);
            e.blue  = shade(CH_BLUE, w.blue, bias);
            corrected_q.push_back(e);
            if (w.line_end)
            begin
                col_ph = 2'd0;
                row_ph = row_ph + 2'd1;
            end
            else
                col_ph = col_ph + 2'd1;
        end
    endtask

    function automatic sample_t random_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return sample_t'($urandom_range(0, 2));
        if (pick == 1)
            return sample_t'($urandom_range(1021, 1023));
        return sample_t'($urandom_range(0, 1023));
    endfunction

    // mostly pixels, some curve writes, a share of them out of range
    function automatic pix_word_t random_word();
        pix_word_t w;
        w.func          = ($urandom_range(0, 99) < 15) ? FUNC_TABLE : FUNC_PIXEL;
        w.red           = random_sample();
        w.green         = random_sample();
        w.blue          = random_sample();
        w.line_end      = ($urandom_range(0, 5) == 0);
        w.frame_start   = ($urandom_range(0, 24) == 0);
        w.table_channel = chan_t'($urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0)
            w.table_index = ptr_t'($urandom_range(17, 31));
        else
            w.table_index = ptr_t'($urandom_range(0, 16));
        w.table_value   = level_t'($urandom_range(0, 255));
        return w;
    endfunction

    task automatic queue_pixel(input sample_t r, input sample_t g, input sample_t b,
                               input logic eol, input logic sof);
        pix_word_t w;
        w             = random_word();
        w.func        = FUNC_PIXEL;
        w.red         = r;
        w.green       = g;
        w.blue        = b;
        w.line_end    = eol;
        w.frame_start = sof;
        word_backlog.push_back(w);
    endtask

    task automatic queue_curve_write(input chan_t ch, input ptr_t idx, input level_t val);
        pix_word_t w;
        w               = random_word();
        w.func          = FUNC_TABLE;
        w.table_channel = ch;
        w.table_index   = idx;
        w.table_value   = val;
        word_backlog.push_back(w);
    endtask

    // wait until every word is taken and every pixel is back
    task automatic wait_drained();
        @(negedge clk);
        while (word_backlog.size() != 0 || bus_valid || corrected_q.size() != 0)
            @(negedge clk);
        // curve writes leave nothing to wait for, so give the pipe time
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // apb write: setup cycle, then access cycle
    task automatic write_reg(input logic [1:0] idx, input logic bit_val);
        logic [31:0] noise;
        noise = $urandom();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {noise[31:1], bit_val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GAMMA_EN:  gamma_on  = bit_val;
            REG_DITHER_EN: dither_on = bit_val;
            REG_TEN_BIT:   wide_in   = bit_val;
            default:       ;
        endcase
    endtask

    task automatic set_config(input logic g, input logic d, input logic t);
        wait_drained();
        write_reg(REG_GAMMA_EN, g);
        write_reg(REG_DITHER_EN, d);
        write_reg(REG_TEN_BIT, t);
        @(negedge clk);
    endtask

    // input driver: offers queued words, holds each until taken
    always @(posedge clk or negedge rst_n)
    begin : feed_words
        logic advance;
        if (!rst_n)
        begin
            bus_valid <= 1'b0;
            col_ph = 2'd0;
            row_ph = 2'd0;
            for (int c = 0; c < NUM_CHAN; c++)
                for (int p = 0; p < CURVE_POINTS; p++)
                    curve_pt[c][p] = POWER_UP_CURVE[8*p +: 8];
        end
        else
        begin
            if (bus_valid && pix_bus.ready)
                absorb_word(bus_word);
            advance = !bus_valid || pix_bus.ready;
            if (advance)
            begin
                if (word_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    bus_word  <= word_backlog.pop_front();
                    bus_valid <= 1'b1;
                end
                else
                    bus_valid <= 1'b0;
            end
        end
    end

    // output side: random stalls plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_ready  <= 1'b0;
            hold_left   <= 0;
            squeeze_ack <= 1'b0;
        end
        else if (squeeze_req != squeeze_ack)
        begin
            squeeze_ack <= squeeze_req;
            hold_left   <= HOLD_CYCLES;
            sink_ready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left  <= hold_left - 1;
            sink_ready <= 1'b0;
        end
        else
            sink_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic check_field(input string name, input level_t want, input level_t got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatch_cnt = mismatch_cnt + 1;
        end
    endtask

    // output monitor: each word against the oldest prediction
    always @(posedge clk)
    begin : check_words
        rgb_word_t want;
        if (rst_n && rgb_bus.valid && sink_ready)
        begin
            if (corrected_q.size() == 0)
            begin
                $display("%0t: unexpected word expected none got %0h %0h %0h", $time,
                         rgb_bus.red_out, rgb_bus.green_out, rgb_bus.blue_out);
                mismatch_cnt = mismatch_cnt + 1;
            end
            else
            begin
                want = corrected_q.pop_front();
                check_field("red_out", want.red, rgb_bus.red_out);
                check_field("green_out", want.green, rgb_bus.green_out);
                check_field("blue_out", want.blue, rgb_bus.blue_out);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((bus_valid && pix_bus.ready) || (rgb_bus.valid && sink_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : run_phases
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // power-up curves, 8-bit samples: extremes, writes, falling segment
        queue_pixel(10'd0, 10'd0, 10'd0, 1'b0, 1'b1);
        queue_pixel(10'h3ff, 10'h3ff, 10'h3ff, 1'b0, 1'b0);
        queue_pixel(10'h2aa, 10'h155, 10'h080, 1'b0, 1'b0);
        queue_curve_write(CH_RED, 5'd0, 8'hff);
        queue_curve_write(CH_GREEN, 5'd16, 8'h00);
        queue_curve_write(CH_BLUE, 5'd5, 8'h00);
        queue_curve_write(CH_NONE, 5'd2, 8'h55);
        queue_curve_write(CH_RED, 5'd17, 8'h11);
        queue_curve_write(CH_BLUE, 5'd31, 8'haa);
        queue_pixel(10'h000, 10'h0ff, 10'h04f, 1'b1, 1'b0);
        queue_pixel(10'h001, 10'h3fe, 10'h041, 1'b0, 1'b0);

        // 10-bit with dither: clamping at both ends across matrix positions
        set_config(1'b1, 1'b1, 1'b1);
        queue_pixel(10'h3ff, 10'h000, 10'h200, 1'b0, 1'b1);
        queue_pixel(10'h3ff, 10'h000, 10'h001, 1'b0, 1'b0);
        queue_pixel(10'h3fe, 10'h001, 10'h3ff, 1'b1, 1'b0);
        queue_pixel(10'h3fe, 10'h001, 10'h3ff, 1'b0, 1'b0);
        queue_pixel(10'h3ff, 10'h002, 10'h155, 1'b0, 1'b0);

        // bypass, dithered 10-bit then plain 8-bit
        set_config(1'b0, 1'b1, 1'b1);
        queue_pixel(10'h3ff, 10'h000, 10'h2aa, 1'b0, 1'b1);
        queue_pixel(10'h3fe, 10'h001, 10'h155, 1'b0, 1'b0);
        set_config(1'b0, 1'b0, 1'b0);
        queue_pixel(10'h3ff, 10'h100, 10'h0ff, 1'b1, 1'b0);
        queue_pixel(10'h000, 10'h2aa, 10'h155, 1'b0, 1'b0);

        // random phases over every setting and every idling mix
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_config(ph[0], ph[1], ph[2]);
            case (ph % 4)
                0:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                1:
                begin
                    send_gap_pct = 54;
                    stall_pct    = 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 54;
                end
                default:
                begin
                    send_gap_pct = 35;
                    stall_pct    = 35;
                end
            endcase
            // long output hold-off while words keep coming
            if (ph == 4)
                squeeze_req <= ~squeeze_req;
            repeat (RANDOM_PER_PHASE) word_backlog.push_back(random_word());
        end

        wait_drained();
        if (mismatch_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: rgb_gamma_interpolate_dither.f
sv/rgi_pkg.sv
sv/rgi_pix_if.sv
sv/rgi_rgb_if.sv
sv/rgi_curve_mem.sv
sv/rgb_gamma_interpolate_dither.sv
bench/testbench.sv
